// File: rtl/bocd_pkg.sv
// Package for the BER octet chunk deframer: shared types and constants.
// Used by the channel interfaces, the parser and the top level. It depends on nothing else.
package bocd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SizeW = 31;
  localparam int unsigned ChunkW = 16;

  localparam logic [ByteW-1:0] TagEoc = 8'h00;
  localparam logic [ByteW-1:0] TagOctets = 8'h04;
  localparam logic [ByteW-1:0] FormIndef = 8'h80;
  localparam logic [ByteW-1:0] FormLong1 = 8'h81;
  localparam logic [ByteW-1:0] FormLong2 = 8'h82;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_OK  = 2'd1,
    ST_ERR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_FORM    = 3'd1,
    PH_LEN1    = 3'd2,
    PH_LENHI   = 3'd3,
    PH_LENLO   = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] packed_byte;
    logic             end_of_buffer;
  } item_t;

  typedef struct packed {
    logic             byte_valid;
    logic [ByteW-1:0] out_byte;
    logic [1:0]       status;
  } result_t;

endpackage

// File: rtl/bocd_if.sv
// Valid/ready channel interfaces for the deframer: input bytes, results and configuration.
// Depends on bocd_pkg for the field widths.
interface bocd_in_if;
  logic                        valid;
  logic                        ready;
  logic [bocd_pkg::ByteW-1:0]  packed_byte;
  logic                        end_of_buffer;

  modport source (output valid, output packed_byte, output end_of_buffer, input ready);
  modport sink (input valid, input packed_byte, input end_of_buffer, output ready);
endinterface

interface bocd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        byte_valid;
  logic [bocd_pkg::ByteW-1:0]  out_byte;
  logic [1:0]                  status;

  modport source (output valid, output byte_valid, output out_byte, output status, input ready);
  modport sink (input valid, input byte_valid, input out_byte, input status, output ready);
endinterface

interface bocd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bocd_pkg::SizeW-1:0]  expected_size;

  modport source (output valid, output expected_size, input ready);
  modport sink (input valid, input expected_size, output ready);
endinterface

// File: rtl/bocd_parser.sv
// Header parser and payload counter: holds the stream state and decides each byte's result.
// Depends on bocd_pkg.
module bocd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  bocd_pkg::item_t               item_i,
  input  logic [bocd_pkg::SizeW-1:0]    expected_size_i,
  output logic                          emit_o,
  output bocd_pkg::result_t             result_o
);
  import bocd_pkg::*;

  phase_e              phase_q, phase_d;
  logic                tag_is_end_q, tag_is_end_d;
  logic [ByteW-1:0]    length_high_q, length_high_d;
  logic [ChunkW-1:0]   chunk_left_q, chunk_left_d;
  logic [SizeW-1:0]    produced_q, produced_d;
  logic                swallow_q, swallow_d;

  status_e             status;
  status_e             finish_st;
  logic                valid;
  logic [ByteW-1:0]    b;
  logic                last;
  logic [ChunkW-1:0]   len;
  logic                len_known;
  logic [ChunkW-1:0]   chunk_dec;

  assign b = item_i.packed_byte;
  assign last = item_i.end_of_buffer;
  assign finish_st = (produced_q == expected_size_i) ? ST_OK : ST_ERR;
  assign chunk_dec = chunk_left_q - ChunkW'(1);

  always_comb begin
    phase_d = phase_q;
    tag_is_end_d = tag_is_end_q;
    length_high_d = length_high_q;
    chunk_left_d = chunk_left_q;
    produced_d = produced_q;
    swallow_d = swallow_q;
    status = ST_RUN;
    valid = 1'b0;
    len = '0;
    len_known = 1'b0;

    if (!swallow_q) begin
      unique case (phase_q)
        PH_TAG: begin
          if (expected_size_i == '0) begin
            status = ST_OK;
          end else if (b == TagEoc) begin
            tag_is_end_d = 1'b1;
            phase_d = PH_FORM;
          end else if (b == TagOctets) begin
            tag_is_end_d = 1'b0;
            phase_d = PH_FORM;
          end else begin
            status = ST_ERR;
          end
        end
        PH_FORM: begin
          if (b == FormIndef) begin
            status = tag_is_end_q ? finish_st : ST_ERR;
          end else if (b == FormLong1) begin
            phase_d = PH_LEN1;
          end else if (b == FormLong2) begin
            phase_d = PH_LENHI;
          end else if (b[ByteW-1]) begin
            status = ST_ERR;
          end else begin
            len = ChunkW'(b);
            len_known = 1'b1;
          end
        end
        PH_LEN1: begin
          if (!b[ByteW-1]) begin
            status = ST_ERR;
          end else begin
            len = ChunkW'(b);
            len_known = 1'b1;
          end
        end
        PH_LENHI: begin
          length_high_d = b;
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          if (length_high_q == '0) begin
            status = ST_ERR;
          end else begin
            len = {length_high_q, b};
            len_known = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (produced_q < expected_size_i) begin
            valid = 1'b1;
            produced_d = produced_q + SizeW'(1);
          end
          chunk_left_d = chunk_dec;
          if (chunk_dec == '0) begin
            phase_d = PH_TAG;
          end
        end
        default: begin
          status = ST_ERR;
        end
      endcase

      // A known length either closes the stream or opens a payload chunk.
      if (len_known) begin
        if (tag_is_end_q) begin
          status = finish_st;
        end else if (len == '0) begin
          status = ST_ERR;
        end else begin
          chunk_left_d = len;
          phase_d = PH_PAYLOAD;
        end
      end

      if (status == ST_RUN && last) begin
        status = ST_ERR;
      end
      if (status == ST_ERR) begin
        valid = 1'b0;
      end
      if (status != ST_RUN) begin
        swallow_d = 1'b1;
      end
    end

    // The flagged last byte always rearms the block once a status has been given.
    if (swallow_d && last) begin
      phase_d = PH_TAG;
      tag_is_end_d = 1'b0;
      length_high_d = '0;
      chunk_left_d = '0;
      produced_d = '0;
      swallow_d = 1'b0;
    end
  end

  assign emit_o = !swallow_q && (valid || status != ST_RUN);
  assign result_o.byte_valid = valid;
  assign result_o.out_byte = valid ? b : '0;
  assign result_o.status = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      tag_is_end_q <= 1'b0;
      length_high_q <= '0;
      chunk_left_q <= '0;
      produced_q <= '0;
      swallow_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tag_is_end_q <= tag_is_end_d;
      length_high_q <= length_high_d;
      chunk_left_q <= chunk_left_d;
      produced_q <= produced_d;
      swallow_q <= swallow_d;
    end
  end

endmodule

// File: rtl/ber_octet_chunk_deframer_unit.sv
// Top level of the BER octet chunk deframer: input register, parser and result register.
// Depends on bocd_pkg, the channel interfaces in bocd_if.sv and bocd_parser.
//
//   channel  dir  words carried
//   in_i     in   packed_byte, end_of_buffer
//   out_o    out  byte_valid, out_byte, status
//   cfg_i    in   expected_size
//
// One byte is accepted per cycle while the result register is not held by a stall on out_o. The
// parser works on it from the input register, and its result is held in the result register that drives out_o.
// Bytes that give no result leave nothing on out_o. Reset clears the stream state and sets
// expected_size to zero. A stall on out_o holds the result register and then the input register;
// the input stays ready whenever the input register is empty or can move on in the same cycle.
module ber_octet_chunk_deframer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  bocd_in_if.sink       in_i,
  bocd_out_if.source    out_o,
  bocd_cfg_if.sink      cfg_i
);
  import bocd_pkg::*;

  logic                 s1_valid_q;
  item_t                s1_item_q;
  logic                 out_valid_q;
  result_t              out_res_q;
  logic [SizeW-1:0]     expected_size_q;
  logic                 adv;
  logic                 emit;
  result_t              res;

  assign adv = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_size_q <= '0;
    end else if (cfg_i.valid) begin
      expected_size_q <= cfg_i.expected_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.packed_byte <= in_i.packed_byte;
      s1_item_q.end_of_buffer <= in_i.end_of_buffer;
    end
  end

  bocd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (adv),
    .item_i          (s1_item_q),
    .expected_size_i (expected_size_q),
    .emit_o          (emit),
    .result_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.byte_valid = out_res_q.byte_valid;
  assign out_o.out_byte = out_res_q.out_byte;
  assign out_o.status = out_res_q.status;

endmodule

// File: sim/bocd_stream_checker.sv
`timescale 1ns / 1ps
// Checker for the BER octet chunk deframer: it watches the input, output and configuration
// channels, predicts each result word and compares it field by field with the one delivered.
// Depends on bocd_pkg and the channel interfaces in bocd_if.sv.
module bocd_stream_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bocd_in_if   in_mon_i,
  bocd_out_if  out_mon_i,
  bocd_cfg_if  cfg_mon_i,
  output int   mismatches_o,
  output int   outstanding_o
);
  import bocd_pkg::*;

  logic [SizeW-1:0]  size_q = '0;
  logic [SizeW-1:0]  made_q = '0;
  phase_e            phase_q = PH_TAG;
  logic              eoc_q = 1'b0;
  logic              swallow_q = 1'b0;
  logic [ByteW-1:0]  len_hi_q = '0;
  logic [ChunkW-1:0] left_q = '0;
  result_t           expected_results[$];
  result_t           want_r;
  result_t           got_r;
  result_t           next_r;
  int                fails = 0;

  function automatic void restart_stream();
    phase_q = PH_TAG;
    eoc_q = 1'b0;
    len_hi_q = '0;
    left_q = '0;
    made_q = '0;
    swallow_q = 1'b0;
  endfunction

  function automatic status_e stream_verdict();
    return (made_q == size_q) ? ST_OK : ST_ERR;
  endfunction

  // An end-of-contents header finishes the stream as soon as its length is known.
  function automatic status_e take_length(input logic [ChunkW-1:0] len);
    if (eoc_q) return stream_verdict();
    if (len == '0) return ST_ERR;
    left_q = len;
    phase_q = PH_PAYLOAD;
    return ST_RUN;
  endfunction

  function automatic bit deframe_byte(input item_t it, output result_t res);
    status_e          st;
    logic             hit;
    logic [ByteW-1:0] b;
    st = ST_RUN;
    hit = 1'b0;
    b = it.packed_byte;
    res = '0;
    if (swallow_q) begin
      if (it.end_of_buffer) restart_stream();
      return 1'b0;
    end
    case (phase_q)
      PH_TAG: begin
        if (size_q == '0) st = ST_OK;
        else if (b == TagEoc) begin
          eoc_q = 1'b1;
          phase_q = PH_FORM;
        end else if (b == TagOctets) begin
          eoc_q = 1'b0;
          phase_q = PH_FORM;
        end else st = ST_ERR;
      end
      PH_FORM: begin
        if (b == FormIndef) st = eoc_q ? stream_verdict() : ST_ERR;
        else if (b == FormLong1) phase_q = PH_LEN1;
        else if (b == FormLong2) phase_q = PH_LENHI;
        else if (b[7]) st = ST_ERR;
        else st = take_length(ChunkW'(b));
      end
      PH_LEN1: st = b[7] ? take_length(ChunkW'(b)) : ST_ERR;
      PH_LENHI: begin
        len_hi_q = b;
        phase_q = PH_LENLO;
      end
      PH_LENLO: st = (len_hi_q == '0) ? ST_ERR : take_length({len_hi_q, b});
      PH_PAYLOAD: begin
        // Payload beyond the configured size is dropped silently.
        if (made_q < size_q) begin
          hit = 1'b1;
          made_q = made_q + 1'b1;
        end
        left_q = left_q - 1'b1;
        if (left_q == '0) phase_q = PH_TAG;
      end
      default: st = ST_ERR;
    endcase
    if (st == ST_RUN && it.end_of_buffer) st = ST_ERR;
    if (st == ST_ERR) hit = 1'b0;
    if (st != ST_RUN) begin
      if (it.end_of_buffer) restart_stream();
      else swallow_q = 1'b1;
    end
    res.byte_valid = hit;
    res.out_byte = hit ? b : '0;
    res.status = st;
    return hit || (st != ST_RUN);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q = '0;
      restart_stream();
      expected_results.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got_r.byte_valid = out_mon_i.byte_valid;
        got_r.out_byte = out_mon_i.out_byte;
        got_r.status = out_mon_i.status;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got valid %0b byte %h status %0d",
                   $time, got_r.byte_valid, got_r.out_byte, got_r.status);
          fails++;
        end else begin
          want_r = expected_results.pop_front();
          if (got_r.byte_valid !== want_r.byte_valid) begin
            $display("%0t: byte_valid mismatch, expected %0b, got %0b",
                     $time, want_r.byte_valid, got_r.byte_valid);
            fails++;
          end
          if (got_r.out_byte !== want_r.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h, got %h",
                     $time, want_r.out_byte, got_r.out_byte);
            fails++;
          end
          if (got_r.status !== want_r.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want_r.status, got_r.status);
            fails++;
          end
        end
      end
      if (cfg_mon_i.valid && cfg_mon_i.ready) size_q = cfg_mon_i.expected_size;
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (deframe_byte('{packed_byte: in_mon_i.packed_byte,
                           end_of_buffer: in_mon_i.end_of_buffer}, next_r))
          expected_results.push_back(next_r);
      end
    end
    mismatches_o <= fails;
    outstanding_o <= expected_results.size();
  end

endmodule

// File: sim/ber_octet_chunk_deframer_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the BER octet chunk deframer: clock, reset, byte streams and size writes.
// Depends on bocd_pkg, bocd_if.sv, the deframer RTL and bocd_stream_checker.
module ber_octet_chunk_deframer_unit_tb;
  import bocd_pkg::*;

  localparam int StallLimit = 1000;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 500;
  localparam logic [SizeW-1:0] SizeMax = {SizeW{1'b1}};

  logic       clk_i;
  logic       rst_ni;
  bit         idle_on;
  bit         tail;
  int         sent_count;
  int         quiet_cycles;
  int         stall_left;
  int         fails;
  int         outstanding;
  item_t      burst_q[$];

  bocd_in_if  in_ch();
  bocd_out_if out_ch();
  bocd_cfg_if cfg_ch();

  ber_octet_chunk_deframer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bocd_stream_checker stream_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (in_ch),
    .out_mon_i     (out_ch),
    .cfg_mon_i     (cfg_ch),
    .mismatches_o  (fails),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output back-pressure in bursts of random length, started only while idle_on is set.
  initial begin
    out_ch.ready = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [ByteW-1:0] b, input logic last);
    burst_q.push_back('{packed_byte: b, end_of_buffer: last});
  endtask

  task automatic send_byte(input item_t it);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.packed_byte <= it.packed_byte;
    in_ch.end_of_buffer <= it.end_of_buffer;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_burst();
    while (burst_q.size() > 0) send_byte(burst_q.pop_front());
  endtask

  // Waits until every expected word is out, then lets bytes without a result drain.
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SizeW-1:0] sz);
    settle();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.expected_size <= sz;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_chunk_header(input int len);
    queue_byte(TagOctets, 1'b0);
    if (len < 'h80) begin
      queue_byte(8'(len), 1'b0);
    end else if (len < 'h100) begin
      queue_byte(FormLong1, 1'b0);
      queue_byte(8'(len), 1'b0);
    end else begin
      queue_byte(FormLong2, 1'b0);
      queue_byte(8'(len >> 8), 1'b0);
      queue_byte(8'(len), 1'b0);
    end
  endtask

  task automatic add_chunk(input int len);
    add_chunk_header(len);
    repeat (len) queue_byte(8'($urandom), 1'b0);
  endtask

  // End of contents in any legal length form, sometimes with junk after it.
  task automatic add_eoc();
    queue_byte(TagEoc, 1'b0);
    case ($urandom_range(0, 5))
      0, 1: queue_byte(8'h00, 1'b0);
      2: queue_byte(FormIndef, 1'b0);
      3: queue_byte(8'($urandom_range(1, 'h7F)), 1'b0);
      4: begin
        queue_byte(FormLong1, 1'b0);
        queue_byte(8'($urandom_range('h80, 'hFF)), 1'b0);
      end
      default: begin
        queue_byte(FormLong2, 1'b0);
        queue_byte(8'($urandom_range(1, 'hFF)), 1'b0);
        queue_byte(8'($urandom), 1'b0);
      end
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
    burst_q[$].end_of_buffer = 1'b1;
  endtask

  task automatic add_good_stream(input int total);
    int left;
    int n;
    left = total;
    while (left > 0) begin
      n = $urandom_range(1, (left < 20) ? left : 20);
      add_chunk(n);
      left -= n;
    end
    if ($urandom_range(0, 14) == 0) add_chunk($urandom_range('h80, 300));
    add_eoc();
  endtask

  task automatic add_broken_stream(input int total);
    int cut;
    case ($urandom_range(0, 3))
      0: begin
        add_good_stream(total);
        cut = $urandom_range(0, burst_q.size() - 1);
        while (burst_q.size() > cut + 1) void'(burst_q.pop_back());
        burst_q[$].end_of_buffer = 1'b1;
      end
      1: begin
        add_good_stream(total);
        burst_q[$urandom_range(0, burst_q.size() - 1)].packed_byte = 8'($urandom);
      end
      2: begin
        // Long length forms cut short, so that any length value is reachable.
        queue_byte(TagOctets, 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          queue_byte(FormLong1, 1'b0);
          queue_byte(8'($urandom), 1'b0);
        end else begin
          queue_byte(FormLong2, 1'b0);
          queue_byte(8'($urandom), 1'b0);
          queue_byte(8'($urandom), 1'b0);
        end
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
        burst_q[$].end_of_buffer = 1'b1;
      end
      default: begin
        queue_byte(TagOctets, 1'b0);
        case ($urandom_range(0, 2))
          0: queue_byte(8'($urandom_range('h83, 'hFF)), 1'b0);
          1: queue_byte(FormIndef, 1'b0);
          default: queue_byte(8'h00, 1'b0);
        endcase
        repeat ($urandom_range(0, 2)) queue_byte(8'($urandom), 1'b0);
        burst_q[$].end_of_buffer = 1'b1;
      end
    endcase
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 8)) queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
    burst_q[$].end_of_buffer = 1'b1;
  endtask

  initial begin
    logic [SizeW-1:0] sz;
    int               p;
    int               base;
    int               phase_start;
    int               total;
    int               pick;

    rst_ni = 1'b0;
    idle_on = 1'b1;
    tail = 1'b0;
    sent_count = 0;
    in_ch.valid = 1'b0;
    in_ch.packed_byte = '0;
    in_ch.end_of_buffer = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.expected_size = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Size zero after reset: the first byte finishes the stream at once.
    queue_byte(TagOctets, 1'b0);
    queue_byte(8'h5A, 1'b1);
    send_burst();

    write_size(SizeW'(3));
    add_chunk_header(3);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(TagEoc, 1'b0);
    queue_byte(8'h00, 1'b1);
    // End of contents with nothing delivered, in the indefinite form.
    queue_byte(TagEoc, 1'b0);
    queue_byte(FormIndef, 1'b1);
    queue_byte(8'h05, 1'b1);
    queue_byte(TagOctets, 1'b0);
    queue_byte(FormIndef, 1'b1);
    queue_byte(TagOctets, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(TagOctets, 1'b0);
    queue_byte(FormLong1, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(TagOctets, 1'b0);
    queue_byte(FormLong2, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    send_burst();

    base = sent_count;
    p = 0;
    while (sent_count - base < RandomItems) begin
      case (p)
        0: sz = SizeMax;
        1: sz = '0;
        2: sz = SizeW'($urandom);
        default: sz = SizeW'($urandom_range(1, 24));
      endcase
      write_size(sz);
      idle_on = !tail && (p % 3 != 2);
      phase_start = sent_count;
      while (sent_count - phase_start < 45 && sent_count - base < RandomItems) begin
        if (sent_count - base > RandomItems * 4 / 5) begin
          tail = 1'b1;
          idle_on = 1'b0;
        end
        total = (sz <= 40) ? int'(sz) : $urandom_range(1, 30);
        pick = $urandom_range(0, 9);
        if (pick < 6) add_good_stream(total);
        else if (pick == 6) add_good_stream(total + $urandom_range(0, 2) - 1);
        else if (pick < 9) add_broken_stream(total);
        else add_noise();
        send_burst();
      end
      p++;
    end

    settle();
    if (fails == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: ber_octet_chunk_deframer_unit.f
rtl/bocd_pkg.sv
rtl/bocd_if.sv
rtl/bocd_parser.sv
rtl/ber_octet_chunk_deframer_unit.sv
sim/bocd_stream_checker.sv
sim/ber_octet_chunk_deframer_unit_tb.sv
